/* hw/rtl/i2cm_pkg.sv */
`timescale 1ns / 1ps
// Package for the I2C bit-level master: operation codes, phase counts,
// queue entry and status types. No dependencies.
package i2cm_pkg;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam logic [4:0] COND_PHASES      = 5'd4;
    localparam logic [4:0] WRITE_PHASES     = 5'd18;
    localparam logic [4:0] READ_PHASES      = 5'd27;
    localparam logic [4:0] WRITE_BIT_PHASES = 5'd16;  // 2 phases per data bit
    localparam logic [4:0] READ_BIT_PHASES  = 5'd24;  // 3 phases per data bit

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd40;

    // register index taken from paddr[2]
    localparam logic REG_PHASE_TICKS = 1'b0;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] write_data;
        logic       send_nack;
        logic       sda_in;
        logic       is_cmd;      // operation is start, stop, write or read
        logic       is_nonzero;  // counts as a rejected command while busy
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic scl;
        logic sda;
        logic oe;
    } t_lines;

    function automatic logic [4:0] phase_total(input logic [2:0] op);
        logic [4:0] total;
        case (op)
            OP_WRITE: total = WRITE_PHASES;
            OP_READ:  total = READ_PHASES;
            default:  total = COND_PHASES;
        endcase
        return total;
    endfunction

endpackage

/* hw/rtl/i2cm_in_if.sv */
`timescale 1ns / 1ps
// Command/tick channel of the I2C bit-level master.
// Standalone; valid/ready handshake.
interface i2cm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [7:0] write_data;
    logic       send_nack;
    logic       sda_in;

    modport source (output valid, operation, write_data, send_nack, sda_in, input ready);
    modport sink   (input valid, operation, write_data, send_nack, sda_in, output ready);
endinterface

/* hw/rtl/i2cm_out_if.sv */
`timescale 1ns / 1ps
// Result channel of the I2C bit-level master: line levels and status per tick.
// Standalone; valid/ready handshake.
interface i2cm_out_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_seen;
    logic       rejected;

    modport source (output valid, scl_level, sda_level, sda_enable, busy_res, done_res,
                    read_byte, ack_seen, rejected, input ready);
    modport sink   (input valid, scl_level, sda_level, sda_enable, busy_res, done_res,
                    read_byte, ack_seen, rejected, output ready);
endinterface

/* hw/rtl/i2cm_front.sv */
`timescale 1ns / 1ps
// Front end: accepts tick transactions, classifies the operation and pushes
// the entry into the queue. Uses i2cm_pkg and i2cm_in_if.
module i2cm_front (
    i2cm_in_if.sink         i_cmd,
    input  i2cm_pkg::t_q_status i_q_status,
    output logic            o_push,
    output i2cm_pkg::t_entry o_entry
);

    assign i_cmd.ready = ~i_q_status.full;
    assign o_push      = i_cmd.valid & ~i_q_status.full;

    always_comb begin
        o_entry.operation  = i_cmd.operation;
        o_entry.write_data = i_cmd.write_data;
        o_entry.send_nack  = i_cmd.send_nack;
        o_entry.sda_in     = i_cmd.sda_in;
        o_entry.is_nonzero = (i_cmd.operation != i2cm_pkg::OP_TICK);
        o_entry.is_cmd     = (i_cmd.operation == i2cm_pkg::OP_START) ||
                             (i_cmd.operation == i2cm_pkg::OP_STOP)  ||
                             (i_cmd.operation == i2cm_pkg::OP_WRITE) ||
                             (i_cmd.operation == i2cm_pkg::OP_READ);
    end

endmodule

/* hw/rtl/i2cm_queue.sv */
`timescale 1ns / 1ps
// Small FIFO between front end and sequencer.
// Uses i2cm_pkg for the status struct and entry type.
module i2cm_queue #(
    parameter int DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  i2cm_pkg::t_entry    i_data,
    input  logic                i_pop,
    output i2cm_pkg::t_entry    o_data,
    output i2cm_pkg::t_q_status o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    i2cm_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

/* hw/rtl/i2cm_engine.sv */
`timescale 1ns / 1ps
// Back end: bus phase sequencer. Consumes one queued tick per cycle unless a
// stalled result holds it, and registers the result. Uses i2cm_pkg and i2cm_out_if.
module i2cm_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [15:0]         i_phase_ticks,
    input  i2cm_pkg::t_entry    i_entry,
    input  i2cm_pkg::t_q_status i_q_status,
    output logic                o_pop,
    i2cm_out_if.source          o_res
);

    // Line levels on entry to a phase; sub is the phase index mod 3 for reads.
    function automatic i2cm_pkg::t_lines enter_phase(
        input logic [2:0]       cmd,
        input logic [4:0]       ph,
        input logic [1:0]       sub,
        input logic [7:0]       shift,
        input logic             nack,
        input i2cm_pkg::t_lines cur
    );
        i2cm_pkg::t_lines l;
        l = cur;
        case (cmd)
            i2cm_pkg::OP_START: begin
                l.oe = 1'b1;
                if (ph == 5'd0)      l.scl = 1'b1;
                else if (ph == 5'd1) l.sda = 1'b1;
                else if (ph == 5'd2) l.sda = 1'b0;
                else                 l.scl = 1'b0;
            end
            i2cm_pkg::OP_STOP: begin
                l.oe = 1'b1;
                if (ph == 5'd0)      l.scl = 1'b0;
                else if (ph == 5'd1) l.sda = 1'b0;
                else if (ph == 5'd2) l.scl = 1'b1;
                else                 l.sda = 1'b1;
            end
            i2cm_pkg::OP_WRITE: begin
                if (ph < i2cm_pkg::WRITE_BIT_PHASES) begin
                    if (!ph[0]) begin
                        l.oe  = 1'b1;
                        l.sda = shift[~ph[3:1]];   // MSB first
                        l.scl = 1'b1;
                    end else begin
                        l.scl = 1'b0;
                    end
                end else if (ph == i2cm_pkg::WRITE_BIT_PHASES) begin
                    l.oe  = 1'b0;
                    l.sda = 1'b0;
                    l.scl = 1'b1;
                end else begin
                    l.scl = 1'b0;
                end
            end
            i2cm_pkg::OP_READ: begin
                if (ph < i2cm_pkg::READ_BIT_PHASES) begin
                    if (sub == 2'd0) begin
                        l.oe  = 1'b0;
                        l.scl = 1'b0;
                    end else if (sub == 2'd1) begin
                        l.scl = 1'b1;
                    end else begin
                        l.scl = 1'b0;
                    end
                end else if (ph == i2cm_pkg::READ_BIT_PHASES) begin
                    l.oe  = 1'b1;
                    l.sda = nack;
                    l.scl = 1'b0;
                end else if (ph == i2cm_pkg::READ_BIT_PHASES + 5'd1) begin
                    l.scl = 1'b1;
                end else begin
                    l.scl = 1'b0;
                end
            end
            default: l = cur;
        endcase
        return l;
    endfunction

    logic [2:0]       r_cmd, n_cmd;
    logic [4:0]       r_phase, n_phase;
    logic [1:0]       r_sub, n_sub;
    logic [15:0]      r_tick, n_tick;
    logic [7:0]       r_shift, n_shift;
    logic             r_nack, n_nack;
    logic             r_ack, n_ack;
    logic [7:0]       r_last, n_last;
    i2cm_pkg::t_lines r_lines, n_lines;

    logic             r_out_valid;
    i2cm_pkg::t_lines r_out_lines, n_out_lines;
    logic             r_out_done, n_done;
    logic             r_out_rej, n_rej;

    logic [15:0] limit;
    logic [16:0] tick_inc;
    logic [4:0]  ph_next;
    logic [1:0]  sub_next;

    assign o_pop = ~i_q_status.empty & (~r_out_valid | o_res.ready);
    assign limit = (i_phase_ticks == 16'd0) ? 16'd1 : i_phase_ticks;

    always_comb begin
        n_cmd       = r_cmd;
        n_phase     = r_phase;
        n_sub       = r_sub;
        n_tick      = r_tick;
        n_shift     = r_shift;
        n_nack      = r_nack;
        n_ack       = r_ack;
        n_last      = r_last;
        n_lines     = r_lines;
        n_done      = 1'b0;
        n_rej       = 1'b0;
        tick_inc    = '0;
        ph_next     = '0;
        sub_next    = '0;

        if (r_cmd == i2cm_pkg::OP_TICK) begin
            if (i_entry.is_cmd) begin
                n_cmd   = i_entry.operation;
                n_phase = '0;
                n_sub   = '0;
                n_tick  = '0;
                n_shift = (i_entry.operation == i2cm_pkg::OP_WRITE) ? i_entry.write_data : 8'd0;
                n_nack  = i_entry.send_nack;
                n_lines = enter_phase(n_cmd, 5'd0, 2'd0, n_shift, n_nack, r_lines);
            end
        end else if (i_entry.is_nonzero) begin
            n_rej = 1'b1;
        end

        // levels reported for this tick are those before any phase change
        n_out_lines = n_lines;

        if (n_cmd != i2cm_pkg::OP_TICK) begin
            tick_inc = {1'b0, n_tick} + 17'd1;
            if (tick_inc >= {1'b0, limit}) begin
                if (n_cmd == i2cm_pkg::OP_WRITE && n_phase == i2cm_pkg::WRITE_BIT_PHASES) begin
                    n_ack = i_entry.sda_in;
                end
                // sample on the last tick of the SCL-high phase
                if (n_cmd == i2cm_pkg::OP_READ && n_phase < i2cm_pkg::READ_BIT_PHASES &&
                    n_sub == 2'd1) begin
                    n_shift = {n_shift[6:0], i_entry.sda_in};
                end
                n_tick   = '0;
                ph_next  = n_phase + 5'd1;
                sub_next = (n_sub == 2'd2) ? 2'd0 : n_sub + 2'd1;
                if (ph_next >= i2cm_pkg::phase_total(n_cmd)) begin
                    if (n_cmd == i2cm_pkg::OP_READ) begin
                        n_last = n_shift;
                    end
                    n_done  = 1'b1;
                    n_cmd   = i2cm_pkg::OP_TICK;
                    n_phase = '0;
                end else begin
                    n_phase = ph_next;
                    n_sub   = sub_next;
                    n_lines = enter_phase(n_cmd, ph_next, sub_next, n_shift, n_nack, n_lines);
                end
            end else begin
                n_tick = tick_inc[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd       <= i2cm_pkg::OP_TICK;
            r_phase     <= '0;
            r_sub       <= '0;
            r_tick      <= '0;
            r_shift     <= '0;
            r_nack      <= 1'b0;
            r_ack       <= 1'b1;
            r_last      <= '0;
            r_lines     <= '{scl: 1'b1, sda: 1'b1, oe: 1'b1};
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cmd   <= n_cmd;
                r_phase <= n_phase;
                r_sub   <= n_sub;
                r_tick  <= n_tick;
                r_shift <= n_shift;
                r_nack  <= n_nack;
                r_ack   <= n_ack;
                r_last  <= n_last;
                r_lines <= n_lines;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_lines <= n_out_lines;
            r_out_done  <= n_done;
            r_out_rej   <= n_rej;
        end
    end

    // busy, read byte and ack are the state after the tick
    assign o_res.valid      = r_out_valid;
    assign o_res.scl_level  = r_out_lines.scl;
    assign o_res.sda_level  = r_out_lines.sda;
    assign o_res.sda_enable = r_out_lines.oe;
    assign o_res.busy_res   = (r_cmd != i2cm_pkg::OP_TICK);
    assign o_res.done_res   = r_out_done;
    assign o_res.read_byte  = r_last;
    assign o_res.ack_seen   = r_ack;
    assign o_res.rejected   = r_out_rej;

endmodule

/* hw/rtl/i2c_bit_level_master_top.sv */
`timescale 1ns / 1ps
// Top level of the I2C bit-level master: APB register, front end, queue, sequencer.
// Uses i2cm_pkg, i2cm_in_if, i2cm_out_if, i2cm_front, i2cm_queue, i2cm_engine.
//
//   channel   direction  handshake          carries
//   i_cmd     in         valid/ready        operation, write_data, send_nack, sda_in
//   o_res     out        valid/ready        line levels, busy, done, read byte, ack, rejected
//   APB       in         psel/penable       phase_ticks at 0x0
//
// One tick per cycle sustained while results are taken; the sequencer updates
// its whole state in one step. A tick is queued, then the sequencer step is
// registered into the result register. Reset is synchronous, active low; it
// empties the queue, idles the sequencer and sets phase_ticks to 40. A stalled
// result holds the sequencer; the queue absorbs QUEUE_DEPTH ticks before ready drops.
module i2c_bit_level_master_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2cm_in_if.sink     i_cmd,
    i2cm_out_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [i2cm_pkg::APB_AW-1:0] paddr,
    input  logic [i2cm_pkg::APB_DW-1:0] pwdata,
    output logic [i2cm_pkg::APB_DW-1:0] prdata,
    output logic        pready
);

    logic [15:0]         r_phase_ticks;
    logic                push, pop;
    i2cm_pkg::t_entry    push_entry, head_entry;
    i2cm_pkg::t_q_status q_status;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= i2cm_pkg::PHASE_TICKS_RESET;
        end else if (psel && penable && pwrite && paddr[2] == i2cm_pkg::REG_PHASE_TICKS) begin
            r_phase_ticks <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == i2cm_pkg::REG_PHASE_TICKS) ?
                    {16'd0, r_phase_ticks} : '0;

    i2cm_front u_front (
        .i_cmd      (i_cmd),
        .i_q_status (q_status),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    i2cm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_entry),
        .i_pop    (pop),
        .o_data   (head_entry),
        .o_status (q_status)
    );

    i2cm_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_phase_ticks (r_phase_ticks),
        .i_entry       (head_entry),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .o_res         (o_res)
    );

    // a finished command leaves the sequencer idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.done_res |-> !o_res.busy_res)
        else $error("done reported while still busy");

    // the sequencer never steps from an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // leaving reset, no result is pending
    a_reset_clear: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_res.valid && q_status.empty)
        else $error("result or queue entry survived reset");

endmodule
